>>> src/damped_sine_pulse_generator_core_defines.svh
// Assertion macros for the damped sine pulse generator core
`ifndef DAMPED_SINE_PULSE_GENERATOR_CORE_DEFINES_SVH
`define DAMPED_SINE_PULSE_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DSPG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define DSPG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/dspg_pkg.sv
// Shared types and constants of the damped sine pulse generator
package dspg_pkg;

  localparam int unsigned TIME_W   = 16;
  localparam int unsigned PEAK_W   = 22;
  localparam int unsigned RATE_W   = 24;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned SPAN_W   = 20;
  localparam int unsigned OFS_W    = 21;
  localparam int unsigned NOISE_W  = 22;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PEAK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd7;

  typedef enum logic [1:0] {
    RD_SELF = 2'd0,
    RD_NEXT = 2'd1,
    RD_FAR  = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    logic    init_en;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    cap_a;
    logic    cap_b;
    logic    twist_wr;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic init_done;
  } status_t;

endpackage

>>> src/dspg_ctrl.sv
// Sequencer of the damped sine pulse generator: init pass, item steps, output handshake
module dspg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output dspg_pkg::cmd_t    cmd_o,
  input  dspg_pkg::status_t status_i
);

  typedef enum logic [7:0] {
    ST_INIT = 8'b0000_0001,
    ST_IDLE = 8'b0000_0010,
    ST_S1   = 8'b0000_0100,
    ST_S2   = 8'b0000_1000,
    ST_S3   = 8'b0001_0000,
    ST_S4   = 8'b0010_0000,
    ST_S5   = 8'b0100_0000,
    ST_S6   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.accept    = 1'b0;
    cmd_o.init_en   = 1'b0;
    cmd_o.rd_en     = 1'b0;
    cmd_o.rd_sel    = dspg_pkg::RD_SELF;
    cmd_o.cap_a     = 1'b0;
    cmd_o.cap_b     = 1'b0;
    cmd_o.twist_wr  = 1'b0;
    cmd_o.out_load  = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.init_en = 1'b1;
        if (status_i.init_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_S1;
        end
      end
      ST_S1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = dspg_pkg::RD_SELF;
        state_d      = ST_S2;
      end
      ST_S2: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = dspg_pkg::RD_NEXT;
        cmd_o.cap_a  = 1'b1;
        state_d      = ST_S3;
      end
      ST_S3: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = dspg_pkg::RD_FAR;
        cmd_o.cap_b  = 1'b1;
        state_d      = ST_S4;
      end
      ST_S4: begin
        cmd_o.twist_wr = 1'b1;
        state_d        = ST_S5;
      end
      ST_S5: begin
        state_d = ST_S6;
      end
      ST_S6: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/dspg_tone.sv
// Tone datapath: envelope, sine lookup, tone product, noise sum and output register
module dspg_tone #(
  parameter int unsigned SINE_ENTRIES = 1024,
  parameter int unsigned EXP_ENTRIES  = 256
) (
  input  logic                                 clk_i,
  input  dspg_pkg::cmd_t                       cmd_i,
  input  logic [dspg_pkg::TIME_W-1:0]          sample_time_i,
  input  logic [dspg_pkg::PEAK_W-1:0]          peak_level_i,
  input  logic [dspg_pkg::RATE_W-1:0]          rise_rate_i,
  input  logic [dspg_pkg::RATE_W-1:0]          fall_rate_i,
  input  logic [dspg_pkg::LEN_W-1:0]           drive_length_i,
  input  logic [dspg_pkg::LEN_W-1:0]           start_delay_i,
  input  logic [dspg_pkg::STEP_W-1:0]          phase_step_i,
  input  logic signed [dspg_pkg::NOISE_W-1:0]  noise_i,
  output logic signed [dspg_pkg::SAMPLE_W-1:0] sample_uv_o,
  output logic                                 clipped_o
);

  localparam int unsigned SB = $clog2(SINE_ENTRIES);
  localparam int unsigned QB = SB - 2;
  localparam int unsigned QN = SINE_ENTRIES / 4;
  localparam int unsigned EB = $clog2(EXP_ENTRIES);
  localparam int unsigned YW = dspg_pkg::LEN_W + dspg_pkg::RATE_W;
  localparam int unsigned MW = dspg_pkg::PEAK_W + 17;
  localparam int unsigned TW = 23;
  localparam logic [63:0] Q30One = 64'd1073741824;
  localparam logic [63:0] PiQ30  = 64'd3373259426;
  localparam logic [63:0] Ln2Q30 = 64'd744261118;
  localparam logic [23:0] ShiftLimit = 24'd17;

  function automatic logic [14:0] sin_q15(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] s;
    term = x;
    sum  = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x) >> 30) * x >> 30;
      case (k)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        7: term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    s = (sum * 64'd32767 + (Q30One >> 1)) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[14:0];
  endfunction

  function automatic logic [16:0] exp_q16(input logic [63:0] z);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    term = Q30One;
    sum  = Q30One;
    for (int k = 1; k <= 12; k++) begin
      term = (term * z) >> 30;
      case (k)
        1:  term = term / 64'd1;
        2:  term = term / 64'd2;
        3:  term = term / 64'd3;
        4:  term = term / 64'd4;
        5:  term = term / 64'd5;
        6:  term = term / 64'd6;
        7:  term = term / 64'd7;
        8:  term = term / 64'd8;
        9:  term = term / 64'd9;
        10: term = term / 64'd10;
        11: term = term / 64'd11;
        default: term = term / 64'd12;
      endcase
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum * 64'd65536 + (Q30One >> 1)) >> 30;
    return r[16:0];
  endfunction

  logic [14:0] sin_tab [QN+1];
  logic [16:0] exp_tab [EXP_ENTRIES];

  for (genvar k = 0; k <= QN; k++) begin : g_sin
    localparam logic [63:0] Angle =
      (64'(4 * k) * PiQ30 + 64'(SINE_ENTRIES)) / 64'(2 * SINE_ENTRIES);
    assign sin_tab[k] = sin_q15(Angle);
  end

  for (genvar j = 0; j < EXP_ENTRIES; j++) begin : g_exp
    localparam logic [63:0] Zarg =
      (64'(j) * Ln2Q30 + 64'(EXP_ENTRIES / 2)) / 64'(EXP_ENTRIES);
    assign exp_tab[j] = exp_q16(Zarg);
  end

  // stage 0
  logic [dspg_pkg::TIME_W-1:0] t_q;

  // stage 1
  logic                        act1_q;
  logic [YW-1:0]               y_q [2];
  logic [dspg_pkg::STEP_W-1:0] ph_q;
  logic                        late;
  logic [dspg_pkg::TIME_W-1:0] tau;
  logic [dspg_pkg::LEN_W-1:0]  ta;
  logic [dspg_pkg::LEN_W-1:0]  dt;
  logic [47:0]                 ph_full;

  // stage 2
  logic                        act2_q;
  logic [MW-1:0]               m1_q;
  logic [16:0]                 p2_q;
  logic signed [15:0]          s2_q;
  logic [16:0]                 pw [2];
  logic [SB-1:0]               sidx;
  logic [QB:0]                 kk;
  logic signed [15:0]          sval;

  // stage 3
  logic                        act3_q;
  logic [MW-1:0]               env_q;
  logic signed [15:0]          s3_q;

  // stage 4
  logic signed [TW-1:0]        tone_q;
  logic signed [38:0]          tprod;

  // output
  logic signed [24:0]          sum;
  logic signed [dspg_pkg::SAMPLE_W-1:0] sample_q;
  logic                        clip_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      t_q <= sample_time_i;
    end
  end

  always_comb begin
    tau     = t_q - start_delay_i;
    late    = tau > drive_length_i;
    ta      = late ? drive_length_i : tau;
    dt      = late ? (tau - drive_length_i) : '0;
    ph_full = 48'(t_q) * 48'(phase_step_i);
  end

  always_ff @(posedge clk_i) begin
    act1_q <= t_q > start_delay_i;
    y_q[0] <= YW'(ta) * YW'(rise_rate_i);
    y_q[1] <= YW'(dt) * YW'(fall_rate_i);
    ph_q   <= ph_full[dspg_pkg::STEP_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (y_q[i][YW-1:16] >= ShiftLimit) begin
        pw[i] = '0;
      end else begin
        pw[i] = exp_tab[y_q[i][15 -: EB]] >> y_q[i][20:16];
      end
    end
    sidx = ph_q[dspg_pkg::STEP_W-1 -: SB];
    kk   = sidx[SB-2] ? ((QB+1)'(QN) - {1'b0, sidx[QB-1:0]}) : {1'b0, sidx[QB-1:0]};
    sval = sidx[SB-1] ? -$signed({1'b0, sin_tab[kk]}) : $signed({1'b0, sin_tab[kk]});
  end

  always_ff @(posedge clk_i) begin
    act2_q <= act1_q;
    m1_q   <= MW'(peak_level_i) * MW'(17'd65536 - pw[0]);
    p2_q   <= pw[1];
    s2_q   <= sval;
  end

  always_ff @(posedge clk_i) begin
    act3_q <= act2_q;
    env_q  <= MW'(m1_q[16 +: dspg_pkg::PEAK_W]) * MW'(p2_q);
    s3_q   <= s2_q;
  end

  assign tprod = 39'(s3_q) * $signed({1'b0, env_q[16 +: dspg_pkg::PEAK_W]});

  always_ff @(posedge clk_i) begin
    tone_q <= act3_q ? TW'(tprod >>> 15) : '0;
  end

  assign sum = 25'(tone_q) + 25'(noise_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      clip_q <= sum[24] ^ sum[23];
      if (sum[24] ^ sum[23]) begin
        sample_q <= sum[24] ? 24'sh800000 : 24'sh7FFFFF;
      end else begin
        sample_q <= sum[23:0];
      end
    end
  end

  assign sample_uv_o = sample_q;
  assign clipped_o   = clip_q;

endmodule

>>> src/dspg_mt.sv
// Noise source: MT19937 word memory with seed pass, per-word twist, tempering and scaling
module dspg_mt (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dspg_pkg::cmd_t                      cmd_i,
  output dspg_pkg::status_t                   status_o,
  input  logic [dspg_pkg::SPAN_W-1:0]         half_span_i,
  input  logic signed [dspg_pkg::OFS_W-1:0]   offset_i,
  output logic signed [dspg_pkg::NOISE_W-1:0] noise_o
);

  localparam int unsigned Words = 624;
  localparam int unsigned AW    = $clog2(Words);
  localparam logic [AW-1:0] LastAddr = AW'(Words - 1);
  localparam logic [AW-1:0] FarStep  = AW'(397);
  localparam logic [AW-1:0] FarWrap  = AW'(Words - 397);
  localparam logic [31:0] Seed      = 32'd5489;
  localparam logic [31:0] InitMult  = 32'd1812433253;
  localparam logic [31:0] Magic     = 32'h9908B0DF;
  localparam logic [31:0] TemperB   = 32'h9D2C5680;
  localparam logic [31:0] TemperC   = 32'hEFC60000;

  logic [31:0]   mem [Words];
  logic [31:0]   rdata_q;
  logic [31:0]   a_q, b_q, prev_q, temper_q;
  logic [AW-1:0] init_idx_q, pos_q;
  logic [AW-1:0] raddr, waddr;
  logic [31:0]   wdata, init_word, mix, nw, y;
  logic          we;
  logic signed [52:0] prod;
  logic signed [dspg_pkg::NOISE_W-1:0] noise_q;

  always_comb begin
    case (cmd_i.rd_sel)
      dspg_pkg::RD_SELF: raddr = pos_q;
      dspg_pkg::RD_NEXT: raddr = (pos_q == LastAddr) ? '0 : pos_q + AW'(1);
      dspg_pkg::RD_FAR:  raddr = (pos_q >= FarWrap) ? pos_q - FarWrap : pos_q + FarStep;
      default:           raddr = pos_q;
    endcase
  end

  always_comb begin
    mix       = prev_q ^ (prev_q >> 30);
    init_word = (init_idx_q == '0) ? Seed : (InitMult * mix) + 32'(init_idx_q);
    y         = {a_q[31], b_q[30:0]};
    nw        = rdata_q ^ (y >> 1) ^ (y[0] ? Magic : '0);
    we        = cmd_i.init_en | cmd_i.twist_wr;
    waddr     = cmd_i.init_en ? init_idx_q : pos_q;
    wdata     = cmd_i.init_en ? init_word : nw;
  end

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] r;
    r = v ^ (v >> 11);
    r = r ^ ((r << 7) & TemperB);
    r = r ^ ((r << 15) & TemperC);
    r = r ^ (r >> 18);
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_en) begin
      prev_q <= init_word;
    end
    if (cmd_i.cap_a) begin
      a_q <= rdata_q;
    end
    if (cmd_i.cap_b) begin
      b_q <= rdata_q;
    end
    if (cmd_i.twist_wr) begin
      temper_q <= temper(nw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_idx_q <= '0;
      pos_q      <= '0;
    end else begin
      if (cmd_i.init_en && init_idx_q != LastAddr) begin
        init_idx_q <= init_idx_q + AW'(1);
      end
      if (cmd_i.twist_wr) begin
        pos_q <= (pos_q == LastAddr) ? '0 : pos_q + AW'(1);
      end
    end
  end

  assign status_o.init_done = cmd_i.init_en && (init_idx_q == LastAddr);

  assign prod = 53'($signed(temper_q)) * $signed({1'b0, half_span_i});

  always_ff @(posedge clk_i) begin
    noise_q <= dspg_pkg::NOISE_W'(prod >>> 31) + dspg_pkg::NOISE_W'(offset_i);
  end

  assign noise_o = noise_q;

endmodule

>>> src/damped_sine_pulse_generator_core.sv
// Top level of the damped sine pulse generator: configuration registers and unit wiring
//
// Input channel: in_valid_i/in_ready_o carry sample_time_i, one sample time per transfer.
// Output channel: out_valid_o/out_ready_i carry sample_uv_o (signed microvolts) and
// clipped_o, exactly one result per input transfer, in order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i at the clock edge;
// write only while the block is idle.
// Sequence: after the input transfer the controller steps through states S1 to S6 and
// loads the result in S6 once the output register is free; it is shown the next cycle.
// One item is in flight at a time. The steps hold three serial reads of the generator
// word memory, which has one read port, the word update and the multiplier chain of the
// envelope. Reset: the generator word memory is seeded by a pass over all 624 words, one
// word per cycle; in_ready_o stays low until it ends. Configuration writes are taken meanwhile.
// Stall: a result waiting on out_ready_i does not stop the next input transfer; the
// following result waits in the last step until the output register is taken.
module damped_sine_pulse_generator_core #(
  parameter int unsigned SINE_ENTRIES = 1024,
  parameter int unsigned EXP_ENTRIES  = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [dspg_pkg::TIME_W-1:0]           sample_time_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [dspg_pkg::SAMPLE_W-1:0]  sample_uv_o,
  output logic                                  clipped_o,
  input  logic                                  cfg_we_i,
  input  logic [dspg_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dspg_pkg::CFG_W-1:0]            cfg_data_i
);

  `include "damped_sine_pulse_generator_core_defines.svh"

  logic [dspg_pkg::PEAK_W-1:0]        peak_q;
  logic [dspg_pkg::RATE_W-1:0]        rise_q, fall_q;
  logic [dspg_pkg::LEN_W-1:0]         drive_q, delay_q;
  logic [dspg_pkg::STEP_W-1:0]        step_q;
  logic [dspg_pkg::SPAN_W-1:0]        span_q;
  logic signed [dspg_pkg::OFS_W-1:0]  offset_q;

  dspg_pkg::cmd_t                     cmd;
  dspg_pkg::status_t                  status;
  logic signed [dspg_pkg::NOISE_W-1:0] noise;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q   <= 22'd1000000;
      rise_q   <= 24'd31517;
      fall_q   <= 24'd4727;
      drive_q  <= 16'd30;
      delay_q  <= 16'd16;
      step_q   <= 32'd858993459;
      span_q   <= 20'd50000;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dspg_pkg::CFG_PEAK:   peak_q   <= cfg_data_i[dspg_pkg::PEAK_W-1:0];
        dspg_pkg::CFG_RISE:   rise_q   <= cfg_data_i[dspg_pkg::RATE_W-1:0];
        dspg_pkg::CFG_FALL:   fall_q   <= cfg_data_i[dspg_pkg::RATE_W-1:0];
        dspg_pkg::CFG_DRIVE:  drive_q  <= cfg_data_i[dspg_pkg::LEN_W-1:0];
        dspg_pkg::CFG_DELAY:  delay_q  <= cfg_data_i[dspg_pkg::LEN_W-1:0];
        dspg_pkg::CFG_STEP:   step_q   <= cfg_data_i[dspg_pkg::STEP_W-1:0];
        dspg_pkg::CFG_SPAN:   span_q   <= cfg_data_i[dspg_pkg::SPAN_W-1:0];
        dspg_pkg::CFG_OFFSET: offset_q <= $signed(cfg_data_i[dspg_pkg::OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  dspg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  dspg_mt u_mt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .half_span_i (span_q),
    .offset_i    (offset_q),
    .noise_o     (noise)
  );

  dspg_tone #(
    .SINE_ENTRIES (SINE_ENTRIES),
    .EXP_ENTRIES  (EXP_ENTRIES)
  ) u_tone (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .sample_time_i  (sample_time_i),
    .peak_level_i   (peak_q),
    .rise_rate_i    (rise_q),
    .fall_rate_i    (fall_q),
    .drive_length_i (drive_q),
    .start_delay_i  (delay_q),
    .phase_step_i   (step_q),
    .noise_i        (noise),
    .sample_uv_o    (sample_uv_o),
    .clipped_o      (clipped_o)
  );

  `DSPG_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)
  `DSPG_ASSERT_IMP(a_load_free, cmd.out_load, !out_valid_o || out_ready_i)
  `DSPG_ASSERT_IMP(a_seed_blocks, cmd.init_en, !in_ready_o && !cmd.twist_wr)

endmodule
